// ===== hw/rtl/esbs_pkg.sv =====
// Shared types, widths and constants for the EDF scheduler with background server.
// Depends on nothing; imported by every module of the block except esbs_ram.
package esbs_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_TASKS_DEF   = 3;
   localparam int QUEUE_DEPTH_DEF = 16;

   // Tasks that have period/cost registers
   localparam int CFG_TASKS = 3;

   // Field widths
   localparam int PERIOD_W   = 10;
   localparam int COST_W     = 10;
   localparam int HYPER_W    = 16;
   localparam int TIME_W     = 32;
   localparam int JOB_COST_W = 16;
   localparam int JOB_ID_W   = 8;
   localparam int TASK_W     = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Depth of the queue between front and back, and of the result queue
   localparam int ITEMQ_DEPTH = 2;
   localparam int RSPQ_DEPTH  = 2;

   // Running-task code for a slot with no periodic task
   localparam logic [TASK_W-1:0] TASK_IDLE = 2'd3;

   // Reset values of the task registers, task 0 in the low slot
   localparam logic [CFG_TASKS-1:0][PERIOD_W-1:0] RST_PERIOD = {10'd6, 10'd12, 10'd4};
   localparam logic [CFG_TASKS-1:0][COST_W-1:0]   RST_COST   = {10'd1, 10'd2, 10'd1};
   localparam logic [HYPER_W-1:0]                 RST_HYPER  = 16'd12;

   // Register map, word index
   typedef enum logic [REG_IDX_W-1:0] {
      REG_PERIOD_A    = 3'd0,
      REG_PERIOD_B    = 3'd1,
      REG_PERIOD_C    = 3'd2,
      REG_COST_A      = 3'd3,
      REG_COST_B      = 3'd4,
      REG_COST_C      = 3'd5,
      REG_HYPERPERIOD = 3'd6
   } reg_idx_type;

   // Item kinds
   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_SUBMIT = 1'b1
   } op_type;

   typedef struct packed {
      logic [CFG_TASKS-1:0][PERIOD_W-1:0] period;
      logic [CFG_TASKS-1:0][COST_W-1:0]   cost;
      logic [HYPER_W-1:0]                 hyperperiod;
   } cfg_type;

   typedef struct packed {
      op_type                  op;
      logic [TIME_W-1:0]       release_time;
      logic [JOB_COST_W-1:0]   job_cost;
   } item_type;

   // Front-to-back item channel
   typedef struct packed {
      logic     valid;
      item_type item;
   } itemq_type;

   typedef struct packed {
      logic [TASK_W-1:0]   running_task;
      logic                aperiodic_served;
      logic                aperiodic_done;
      logic [JOB_ID_W-1:0] done_job_id;
      logic [TIME_W-1:0]   done_time;
      logic                queue_full;
   } rsp_type;

   // One aperiodic job as stored in the job RAM
   typedef struct packed {
      logic [TIME_W-1:0]     release_time;
      logic [JOB_COST_W-1:0] cost;
      logic [JOB_ID_W-1:0]   id;
   } job_type;

endpackage

// ===== hw/rtl/edf_scheduler_with_background_server.sv =====
// EDF scheduler for periodic tasks with a background server for aperiodic jobs.
// A result is registered into the result queue as the back end accepts its beat
// from the intake queue, then shows on the rsp_ ports. Throughput: one beat per
// cycle unless the result queue is full and not popped, set by the combinational
// EDF compare and head-job RAM read, addressed by head_in with write forwarding.
// Reset (synchronous): registers to defaults, task state, times and queues cleared;
// the job RAM is not cleared and needs no clearing pass.
module edf_scheduler_with_background_server #(
   parameter int NUM_TASKS   = esbs_pkg::NUM_TASKS_DEF,
   parameter int QUEUE_DEPTH = esbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_action,
   input  logic [esbs_pkg::TIME_W-1:0]          req_release_time,
   input  logic [esbs_pkg::JOB_COST_W-1:0]      req_job_cost,
   // result channel
   output logic                                 empty,
   input  logic                                 pop,
   output logic [esbs_pkg::TASK_W-1:0]          rsp_running_task,
   output logic                                 rsp_aperiodic_served,
   output logic                                 rsp_aperiodic_done,
   output logic [esbs_pkg::JOB_ID_W-1:0]        rsp_done_job_id,
   output logic [esbs_pkg::TIME_W-1:0]          rsp_done_time,
   output logic                                 rsp_queue_full,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [esbs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [esbs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [esbs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import esbs_pkg::*;

   cfg_type   cfg;
   itemq_type itemq;
   logic      item_pop;
   rsp_type   rsp;

   esbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_release_time (req_release_time),
      .req_job_cost     (req_job_cost),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .cfg              (cfg),
      .itemq            (itemq),
      .item_pop         (item_pop)
   );

   esbs_back #(
      .NUM_TASKS   (NUM_TASKS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .itemq    (itemq),
      .item_pop (item_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   // Result fields
   assign rsp_running_task     = rsp.running_task;
   assign rsp_aperiodic_served = rsp.aperiodic_served;
   assign rsp_aperiodic_done   = rsp.aperiodic_done;
   assign rsp_done_job_id      = rsp.done_job_id;
   assign rsp_done_time        = rsp.done_time;
   assign rsp_queue_full       = rsp.queue_full;

endmodule

// ===== hw/rtl/esbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module esbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/esbs_front.sv =====
// Front end: configuration registers and the intake queue that decodes each beat.
// Depends on esbs_pkg.
module esbs_front (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_action,
   input  logic [esbs_pkg::TIME_W-1:0]          req_release_time,
   input  logic [esbs_pkg::JOB_COST_W-1:0]      req_job_cost,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [esbs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [esbs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [esbs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   // to back end
   output esbs_pkg::cfg_type                    cfg,
   output esbs_pkg::itemq_type                  itemq,
   input  logic                                 item_pop
);
   import esbs_pkg::*;

   localparam int PTR_W = $clog2(ITEMQ_DEPTH);
   localparam int CNT_W = $clog2(ITEMQ_DEPTH + 1);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type reg_idx;
   logic        csr_wr;

   item_type          item_ff [ITEMQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push_ok;
   logic              pop_ok;
   item_type          new_item;

   // Register write and read decode
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_PERIOD_A:    cfg_in.period[0]   = pwdata[PERIOD_W-1:0];
            REG_PERIOD_B:    cfg_in.period[1]   = pwdata[PERIOD_W-1:0];
            REG_PERIOD_C:    cfg_in.period[2]   = pwdata[PERIOD_W-1:0];
            REG_COST_A:      cfg_in.cost[0]     = pwdata[COST_W-1:0];
            REG_COST_B:      cfg_in.cost[1]     = pwdata[COST_W-1:0];
            REG_COST_C:      cfg_in.cost[2]     = pwdata[COST_W-1:0];
            REG_HYPERPERIOD: cfg_in.hyperperiod = pwdata[HYPER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PERIOD_A:    prdata = CSR_DATA_W'(cfg_ff.period[0]);
         REG_PERIOD_B:    prdata = CSR_DATA_W'(cfg_ff.period[1]);
         REG_PERIOD_C:    prdata = CSR_DATA_W'(cfg_ff.period[2]);
         REG_COST_A:      prdata = CSR_DATA_W'(cfg_ff.cost[0]);
         REG_COST_B:      prdata = CSR_DATA_W'(cfg_ff.cost[1]);
         REG_COST_C:      prdata = CSR_DATA_W'(cfg_ff.cost[2]);
         REG_HYPERPERIOD: prdata = CSR_DATA_W'(cfg_ff.hyperperiod);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period      <= RST_PERIOD;
         cfg_ff.cost        <= RST_COST;
         cfg_ff.hyperperiod <= RST_HYPER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Intake queue: classify the beat and hold it for the back end
   assign full    = (cnt_ff == CNT_W'(ITEMQ_DEPTH));
   assign push_ok = push && !full;
   assign pop_ok  = item_pop && (cnt_ff != '0);

   always_comb begin
      new_item.op           = op_type'(req_action);
      new_item.release_time = req_release_time;
      new_item.job_cost     = req_job_cost;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ITEMQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ITEMQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign itemq.valid = (cnt_ff != '0);
   assign itemq.item  = item_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/esbs_back.sv =====
// Back end: EDF pick over the periodic tasks, aperiodic job queue and result queue.
// Depends on esbs_pkg and esbs_ram.
module esbs_back #(
   parameter int NUM_TASKS   = esbs_pkg::NUM_TASKS_DEF,
   parameter int QUEUE_DEPTH = esbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  esbs_pkg::cfg_type    cfg,
   input  esbs_pkg::itemq_type  itemq,
   output logic                 item_pop,
   input  logic                 pop,
   output logic                 empty,
   output esbs_pkg::rsp_type    rsp
);
   import esbs_pkg::*;

   localparam int TIDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int RPTR_W  = $clog2(RSPQ_DEPTH);
   localparam int RCNT_W  = $clog2(RSPQ_DEPTH + 1);
   localparam int JOB_W   = $bits(job_type);

   // Per-task configuration, absent tasks read as zero
   logic [PERIOD_W-1:0] per_t      [NUM_TASKS];
   logic [COST_W-1:0]   cost_t     [NUM_TASKS];
   logic [COST_W-1:0]   rst_cost_t [NUM_TASKS];
   logic [HYPER_W:0]    dl_t       [NUM_TASKS];
   logic                elig_t     [NUM_TASKS];

   // Periodic task state
   logic [HYPER_W-1:0]  na_ff [NUM_TASKS];
   logic [HYPER_W-1:0]  na_in [NUM_TASKS];
   logic [COST_W-1:0]   rc_ff [NUM_TASKS];
   logic [COST_W-1:0]   rc_in [NUM_TASKS];
   logic [HYPER_W-1:0]  local_ff, local_in;
   logic [TIME_W-1:0]   abs_ff, abs_in;

   // Aperiodic job queue
   logic [QIDX_W-1:0]     head_ff, head_in;
   logic [QIDX_W-1:0]     tail_ff, tail_in;
   logic [QCNT_W-1:0]     jcnt_ff, jcnt_in;
   logic [JOB_ID_W-1:0]   next_id_ff, next_id_in;
   logic [JOB_COST_W-1:0] served_ff, served_in;
   logic                  jwr_en;
   job_type               jwr_job;
   logic [JOB_W-1:0]      ram_rd_data;
   logic                  fwd_valid_ff, fwd_valid_in;
   job_type               fwd_job_ff;
   job_type               head_job;
   logic [JOB_COST_W-1:0] head_rem;

   // EDF pick
   logic                best_found;
   logic [TIDX_W-1:0]   best_idx;
   logic [HYPER_W:0]    best_dl;
   logic [HYPER_W:0]    local_sum;

   // Result queue
   rsp_type            rsp_ff [RSPQ_DEPTH];
   rsp_type            res_in;
   logic [RPTR_W-1:0]  rwr_ptr_ff, rwr_ptr_in;
   logic [RPTR_W-1:0]  rrd_ptr_ff, rrd_ptr_in;
   logic [RCNT_W-1:0]  rcnt_ff, rcnt_in;
   logic               rpop_ok;
   logic               exec;

   // Lane setup: config, reset cost, deadline and eligibility per task
   for (genvar t = 0; t < NUM_TASKS; t++) begin : g_lane
      if (t < CFG_TASKS) begin : g_cfg
         assign per_t[t]      = cfg.period[t];
         assign cost_t[t]     = cfg.cost[t];
         assign rst_cost_t[t] = RST_COST[t];
      end else begin : g_absent
         assign per_t[t]      = '0;
         assign cost_t[t]     = '0;
         assign rst_cost_t[t] = '0;
      end
      assign dl_t[t]   = {1'b0, na_ff[t]} + (HYPER_W + 1)'(per_t[t]);
      assign elig_t[t] = (per_t[t] != '0) && (na_ff[t] < cfg.hyperperiod)
                         && (na_ff[t] <= local_ff);
   end

   // Earliest deadline among eligible tasks, lowest index wins ties
   always_comb begin
      best_found = 1'b0;
      best_idx   = '0;
      best_dl    = '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
         if (elig_t[t] && (!best_found || dl_t[t] < best_dl)) begin
            best_found = 1'b1;
            best_idx   = TIDX_W'(t);
            best_dl    = dl_t[t];
         end
      end
   end

   // Head job: forwarded beat when it was just written into an empty queue
   assign head_job = fwd_valid_ff ? fwd_job_ff : job_type'(ram_rd_data);
   assign head_rem = head_job.cost - served_ff;

   // Result queue handshake
   assign rpop_ok  = pop && (rcnt_ff != '0);
   assign exec     = itemq.valid && ((rcnt_ff != RCNT_W'(RSPQ_DEPTH)) || rpop_ok);
   assign item_pop = exec;
   assign local_sum = {1'b0, local_ff} + 1'b1;

   always_comb begin
      jwr_job.release_time = itemq.item.release_time;
      jwr_job.cost         = itemq.item.job_cost;
      jwr_job.id           = next_id_ff;
   end

   // Execute one beat
   always_comb begin
      for (int t = 0; t < NUM_TASKS; t++) begin
         na_in[t] = na_ff[t];
         rc_in[t] = rc_ff[t];
      end
      local_in   = local_ff;
      abs_in     = abs_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      jcnt_in    = jcnt_ff;
      next_id_in = next_id_ff;
      served_in  = served_ff;
      jwr_en     = 1'b0;
      res_in     = '0;
      if (exec) begin
         case (itemq.item.op)
            OP_SUBMIT: begin
               if (jcnt_ff == QCNT_W'(QUEUE_DEPTH)) begin
                  res_in.queue_full = 1'b1;
               end else begin
                  jwr_en     = 1'b1;
                  tail_in    = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  jcnt_in    = jcnt_ff + 1'b1;
                  next_id_in = next_id_ff + 1'b1;
               end
            end
            OP_TICK: begin
               res_in.running_task = TASK_IDLE;
               if (best_found) begin
                  res_in.running_task = TASK_W'(best_idx);
                  // update only the chosen lane
                  for (int t = 0; t < NUM_TASKS; t++) begin
                     if (best_idx == TIDX_W'(t)) begin
                        if (rc_ff[t] <= COST_W'(1)) begin
                           na_in[t] = (dl_t[t] >= {1'b0, cfg.hyperperiod}) ?
                                      cfg.hyperperiod : dl_t[t][HYPER_W-1:0];
                           rc_in[t] = cost_t[t];
                        end else begin
                           rc_in[t] = rc_ff[t] - 1'b1;
                        end
                     end
                  end
               end else if (jcnt_ff != '0 && head_job.release_time <= abs_ff) begin
                  res_in.aperiodic_served = 1'b1;
                  if (head_rem <= JOB_COST_W'(1)) begin
                     res_in.aperiodic_done = 1'b1;
                     res_in.done_job_id    = head_job.id;
                     res_in.done_time      = abs_ff;
                     head_in   = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     jcnt_in   = jcnt_ff - 1'b1;
                     served_in = '0;
                  end else begin
                     served_in = served_ff + 1'b1;
                  end
               end
               // local time wrap restarts every task
               if (local_sum >= {1'b0, cfg.hyperperiod}) begin
                  local_in = '0;
                  for (int t = 0; t < NUM_TASKS; t++) begin
                     na_in[t] = '0;
                     rc_in[t] = cost_t[t];
                  end
               end else begin
                  local_in = local_sum[HYPER_W-1:0];
               end
               abs_in = abs_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign fwd_valid_in = jwr_en && (tail_ff == head_in);

   esbs_ram #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (jwr_en),
      .wr_addr (tail_ff),
      .wr_data (JOB_W'(jwr_job)),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // Result queue pointers
   always_comb begin
      rwr_ptr_in = rwr_ptr_ff;
      rrd_ptr_in = rrd_ptr_ff;
      rcnt_in    = rcnt_ff;
      if (exec) begin
         rwr_ptr_in = (rwr_ptr_ff == RPTR_W'(RSPQ_DEPTH - 1)) ? '0 : rwr_ptr_ff + 1'b1;
      end
      if (rpop_ok) begin
         rrd_ptr_in = (rrd_ptr_ff == RPTR_W'(RSPQ_DEPTH - 1)) ? '0 : rrd_ptr_ff + 1'b1;
      end
      if (exec && !rpop_ok) begin
         rcnt_in = rcnt_ff + 1'b1;
      end else if (rpop_ok && !exec) begin
         rcnt_in = rcnt_ff - 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TASKS; t++) begin
            na_ff[t] <= '0;
            rc_ff[t] <= rst_cost_t[t];
         end
         local_ff     <= '0;
         abs_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         jcnt_ff      <= '0;
         next_id_ff   <= '0;
         served_ff    <= '0;
         fwd_valid_ff <= 1'b0;
         rwr_ptr_ff   <= '0;
         rrd_ptr_ff   <= '0;
         rcnt_ff      <= '0;
      end else begin
         for (int t = 0; t < NUM_TASKS; t++) begin
            na_ff[t] <= na_in[t];
            rc_ff[t] <= rc_in[t];
         end
         local_ff     <= local_in;
         abs_ff       <= abs_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         jcnt_ff      <= jcnt_in;
         next_id_ff   <= next_id_in;
         served_ff    <= served_in;
         fwd_valid_ff <= fwd_valid_in;
         rwr_ptr_ff   <= rwr_ptr_in;
         rrd_ptr_ff   <= rrd_ptr_in;
         rcnt_ff      <= rcnt_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      fwd_job_ff <= jwr_job;
      if (exec) begin
         rsp_ff[rwr_ptr_ff] <= res_in;
      end
   end

   assign empty = (rcnt_ff == '0);
   assign rsp   = rsp_ff[rrd_ptr_ff];

   // Checks
   a_jcnt_range: assert property (@(posedge clock) disable iff (reset)
      jcnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue count above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (jcnt_ff == '0 || jcnt_ff == QCNT_W'(QUEUE_DEPTH)) |-> (head_ff == tail_ff))
      else $error("job queue pointers disagree with count");

   a_serve_needs_job: assert property (@(posedge clock) disable iff (reset)
      (exec && jcnt_ff == '0) |-> !res_in.aperiodic_served)
      else $error("aperiodic slot served from an empty queue");

   a_local_wrap: assert property (@(posedge clock) disable iff (reset)
      (exec && itemq.item.op == OP_TICK) |=>
         (local_ff == '0 || local_ff < $past(cfg.hyperperiod)))
      else $error("local time not wrapped at hyperperiod");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (rcnt_ff == RCNT_W'(RSPQ_DEPTH) && !rpop_ok) |-> !exec)
      else $error("result written into a full result queue");

endmodule
